FILE: src/bpsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsh_pkg
// Types and constants shared by the battery poll scheduler.
// ----------------------------------------------------------------------------
package bpsh_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned VAL_W    = 16;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  // result action codes
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_PIN    = 2'd1;
  localparam logic [1:0] ACT_CHARGE = 2'd2;
  localparam logic [1:0] ACT_TIME   = 2'd3;

  // low condition codes
  localparam logic [1:0] LOW_NOT     = 2'd0;
  localparam logic [1:0] LOW_YES     = 2'd1;
  localparam logic [1:0] LOW_UNKNOWN = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_ALARM    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_IVL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_FIRST   = 3'd6;

  // configuration reset values
  localparam logic [VAL_W-1:0]  RST_LOW_LIMIT    = 16'd8;
  localparam logic [VAL_W-1:0]  RST_HIGH_LIMIT   = 16'd10;
  localparam logic [TIME_W-1:0] RST_SCAN_IVL     = 32'd60000;
  localparam logic [TIME_W-1:0] RST_CHARGE_FIRST = 32'd75000;
  localparam logic [TIME_W-1:0] RST_TIME_FIRST   = 32'd90000;

  // status word: set means discharging
  localparam int unsigned STATUS_DIS_BIT = 6;

  typedef struct packed {
    logic              enable;
    logic              use_alarm;
    logic [VAL_W-1:0]  low_limit;
    logic [VAL_W-1:0]  high_limit;
    logic [TIME_W-1:0] scan_interval;
    logic [TIME_W-1:0] charge_first_interval;
    logic [TIME_W-1:0] time_first_interval;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              alarm_pin;
    logic              charge_ok;
    logic [VAL_W-1:0]  charge_value;
    logic              status_ok;
    logic [VAL_W-1:0]  status_value;
    logic              empty_ok;
    logic [VAL_W-1:0]  empty_value;
    logic              full_ok;
    logic [VAL_W-1:0]  full_value;
  } poll_t;

  typedef struct packed {
    logic             warning;
    logic [1:0]       action;
    logic             charge_known;
    logic [VAL_W-1:0] charge_level;
    logic [1:0]       low_state;
    logic             charging_known;
    logic             is_charging;
    logic             time_known;
    logic [VAL_W-1:0] time_minutes;
  } res_t;

endpackage

FILE: src/bpsh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsh_in_if / bpsh_out_if
// Valid/ready channels for poll beats and result beats.
// ----------------------------------------------------------------------------
interface bpsh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        alarm_pin;
  logic        charge_ok;
  logic [15:0] charge_value;
  logic        status_ok;
  logic [15:0] status_value;
  logic        empty_ok;
  logic [15:0] empty_value;
  logic        full_ok;
  logic [15:0] full_value;

  modport source (
    output valid, now_ms, alarm_pin, charge_ok, charge_value, status_ok, status_value,
           empty_ok, empty_value, full_ok, full_value,
    input  ready
  );
  modport sink (
    input  valid, now_ms, alarm_pin, charge_ok, charge_value, status_ok, status_value,
           empty_ok, empty_value, full_ok, full_value,
    output ready
  );
endinterface

interface bpsh_out_if;
  logic        valid;
  logic        ready;
  logic        warning;
  logic [1:0]  action;
  logic        charge_known;
  logic [15:0] charge_level;
  logic [1:0]  low_state;
  logic        charging_known;
  logic        is_charging;
  logic        time_known;
  logic [15:0] time_minutes;

  modport source (
    output valid, warning, action, charge_known, charge_level, low_state,
           charging_known, is_charging, time_known, time_minutes,
    input  ready
  );
  modport sink (
    input  valid, warning, action, charge_known, charge_level, low_state,
           charging_known, is_charging, time_known, time_minutes,
    output ready
  );
endinterface

FILE: src/bpsh_sched.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsh_sched
// Scan scheduler state and hysteresis; result of the accepted beat is
// formed combinationally from the current state and the poll beat.
// ----------------------------------------------------------------------------
module bpsh_sched (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  bpsh_pkg::cfg_t cfg,
  input  bpsh_pkg::poll_t poll,
  output bpsh_pkg::res_t res
);

  logic [bpsh_pkg::TIME_W-1:0] last_pin_r, last_pin_nxt;
  logic [bpsh_pkg::TIME_W-1:0] last_chg_r, last_chg_nxt;
  logic [bpsh_pkg::TIME_W-1:0] last_tim_r, last_tim_nxt;
  logic                        chg_first_r, chg_first_nxt;
  logic                        tim_first_r, tim_first_nxt;
  logic [1:0]                  low_r, low_nxt;
  logic                        latch_r, latch_nxt;
  logic                        chg_flag_r, chg_flag_nxt;
  logic [bpsh_pkg::VAL_W-1:0]  chg_store_r, chg_store_nxt;
  logic                        chgng_flag_r, chgng_flag_nxt;
  logic                        chgng_state_r, chgng_state_nxt;
  logic                        tim_flag_r, tim_flag_nxt;
  logic [bpsh_pkg::VAL_W-1:0]  tim_store_r, tim_store_nxt;

  logic [bpsh_pkg::TIME_W-1:0] civ, tiv;
  logic [bpsh_pkg::TIME_W-1:0] d_pin, d_chg, d_tim;
  logic                        due_pin, due_chg, due_tim;
  logic                        dis, rd_ok;
  logic                        warn;
  logic [1:0]                  action;

  assign civ = chg_first_r ? cfg.charge_first_interval : cfg.scan_interval;
  assign tiv = tim_first_r ? cfg.time_first_interval : cfg.scan_interval;

  // wrapping differences, strict compare
  assign d_pin   = poll.now_ms - last_pin_r;
  assign d_chg   = poll.now_ms - last_chg_r;
  assign d_tim   = poll.now_ms - last_tim_r;
  assign due_pin = d_pin > cfg.scan_interval;
  assign due_chg = d_chg > civ;
  assign due_tim = d_tim > tiv;

  assign dis   = poll.status_value[bpsh_pkg::STATUS_DIS_BIT];
  assign rd_ok = dis ? poll.empty_ok : poll.full_ok;

  always_comb begin
    last_pin_nxt    = last_pin_r;
    last_chg_nxt    = last_chg_r;
    last_tim_nxt    = last_tim_r;
    chg_first_nxt   = chg_first_r;
    tim_first_nxt   = tim_first_r;
    low_nxt         = low_r;
    latch_nxt       = latch_r;
    chg_flag_nxt    = chg_flag_r;
    chg_store_nxt   = chg_store_r;
    chgng_flag_nxt  = chgng_flag_r;
    chgng_state_nxt = chgng_state_r;
    tim_flag_nxt    = tim_flag_r;
    tim_store_nxt   = tim_store_r;
    warn            = 1'b0;
    action          = bpsh_pkg::ACT_NONE;

    if (cfg.enable) begin
      if (cfg.use_alarm) begin
        if (due_pin) begin
          last_pin_nxt = poll.now_ms;
          latch_nxt    = ~poll.alarm_pin;
          action       = bpsh_pkg::ACT_PIN;
        end
        warn = latch_nxt;
      end else begin
        if (due_chg) begin
          last_chg_nxt  = poll.now_ms;
          chg_first_nxt = 1'b0;
          action        = bpsh_pkg::ACT_CHARGE;
          if (poll.charge_ok) begin
            chg_store_nxt = poll.charge_value;
            chg_flag_nxt  = 1'b1;
            if (low_r == bpsh_pkg::LOW_NOT) begin
              if (poll.charge_value < cfg.low_limit) begin
                low_nxt = bpsh_pkg::LOW_YES;
              end
            end else if (poll.charge_value > cfg.high_limit) begin
              low_nxt = bpsh_pkg::LOW_NOT;
            end
          end else begin
            chg_flag_nxt = 1'b0;
            low_nxt      = bpsh_pkg::LOW_UNKNOWN;
          end
        end else if (due_tim) begin
          last_tim_nxt  = poll.now_ms;
          tim_first_nxt = 1'b0;
          action        = bpsh_pkg::ACT_TIME;
          if (!poll.status_ok) begin
            chgng_flag_nxt = 1'b0;
            tim_flag_nxt   = 1'b0;
          end else begin
            chgng_state_nxt = ~dis;
            chgng_flag_nxt  = 1'b1;
            tim_flag_nxt    = rd_ok;
            if (rd_ok) begin
              tim_store_nxt = dis ? poll.empty_value : poll.full_value;
            end
          end
        end
        latch_nxt = (low_nxt == bpsh_pkg::LOW_YES);
        warn      = latch_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pin_r    <= '0;
      last_chg_r    <= '0;
      last_tim_r    <= '0;
      chg_first_r   <= 1'b1;
      tim_first_r   <= 1'b1;
      low_r         <= bpsh_pkg::LOW_NOT;
      latch_r       <= 1'b0;
      chg_flag_r    <= 1'b0;
      chg_store_r   <= '0;
      chgng_flag_r  <= 1'b0;
      chgng_state_r <= 1'b0;
      tim_flag_r    <= 1'b0;
      tim_store_r   <= '0;
    end else if (acc) begin
      last_pin_r    <= last_pin_nxt;
      last_chg_r    <= last_chg_nxt;
      last_tim_r    <= last_tim_nxt;
      chg_first_r   <= chg_first_nxt;
      tim_first_r   <= tim_first_nxt;
      low_r         <= low_nxt;
      latch_r       <= latch_nxt;
      chg_flag_r    <= chg_flag_nxt;
      chg_store_r   <= chg_store_nxt;
      chgng_flag_r  <= chgng_flag_nxt;
      chgng_state_r <= chgng_state_nxt;
      tim_flag_r    <= tim_flag_nxt;
      tim_store_r   <= tim_store_nxt;
    end
  end

  always_comb begin
    res.warning        = warn;
    res.action         = action;
    res.charge_known   = chg_flag_nxt;
    res.charge_level   = chg_store_nxt;
    res.low_state      = low_nxt;
    res.charging_known = chgng_flag_nxt;
    res.is_charging    = chgng_state_nxt;
    res.time_known     = tim_flag_nxt;
    res.time_minutes   = tim_store_nxt;
  end

endmodule

FILE: src/battery_poll_scheduler_hysteresis_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_poll_scheduler_hysteresis_unit
// Throughput: one poll beat per cycle while the skid register is empty;
// a two-entry result buffer (output register plus skid register) keeps
// input open while one result waits; ready drops while both are full.
// Reset: synchronous, active low; clears configuration to defaults, the
// scan scheduler state and the result buffer.
// ----------------------------------------------------------------------------
module battery_poll_scheduler_hysteresis_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  bpsh_in_if.sink                             in_ch,
  bpsh_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [bpsh_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [bpsh_pkg::CFG_W-1:0]          cfg_data
);

  bpsh_pkg::cfg_t  cfg_r;
  bpsh_pkg::poll_t poll;
  bpsh_pkg::res_t  res;
  bpsh_pkg::res_t  out_r;
  bpsh_pkg::res_t  skid_r;
  logic            out_valid_r;
  logic            skid_valid_r;
  logic            acc;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable                <= 1'b0;
      cfg_r.use_alarm             <= 1'b0;
      cfg_r.low_limit             <= bpsh_pkg::RST_LOW_LIMIT;
      cfg_r.high_limit            <= bpsh_pkg::RST_HIGH_LIMIT;
      cfg_r.scan_interval         <= bpsh_pkg::RST_SCAN_IVL;
      cfg_r.charge_first_interval <= bpsh_pkg::RST_CHARGE_FIRST;
      cfg_r.time_first_interval   <= bpsh_pkg::RST_TIME_FIRST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        bpsh_pkg::REG_ENABLE:       cfg_r.enable <= cfg_data[0];
        bpsh_pkg::REG_USE_ALARM:    cfg_r.use_alarm <= cfg_data[0];
        bpsh_pkg::REG_LOW_LIMIT:    cfg_r.low_limit <= cfg_data[bpsh_pkg::VAL_W-1:0];
        bpsh_pkg::REG_HIGH_LIMIT:   cfg_r.high_limit <= cfg_data[bpsh_pkg::VAL_W-1:0];
        bpsh_pkg::REG_SCAN_IVL:     cfg_r.scan_interval <= cfg_data;
        bpsh_pkg::REG_CHARGE_FIRST: cfg_r.charge_first_interval <= cfg_data;
        bpsh_pkg::REG_TIME_FIRST:   cfg_r.time_first_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  assign poll.now_ms       = in_ch.now_ms;
  assign poll.alarm_pin    = in_ch.alarm_pin;
  assign poll.charge_ok    = in_ch.charge_ok;
  assign poll.charge_value = in_ch.charge_value;
  assign poll.status_ok    = in_ch.status_ok;
  assign poll.status_value = in_ch.status_value;
  assign poll.empty_ok     = in_ch.empty_ok;
  assign poll.empty_value  = in_ch.empty_value;
  assign poll.full_ok      = in_ch.full_ok;
  assign poll.full_value   = in_ch.full_value;

  assign in_ch.ready = ~skid_valid_r;
  assign acc         = in_ch.valid & ~skid_valid_r;

  bpsh_sched u_sched (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .cfg   (cfg_r),
    .poll  (poll),
    .res   (res)
  );

  // result buffer: output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ch.ready) begin
      if (acc) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ch.ready) begin
      if (acc) begin
        skid_r <= res;
      end
    end else if (skid_valid_r) begin
      out_r <= skid_r;
    end else if (acc) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.warning        = out_r.warning;
  assign out_ch.action         = out_r.action;
  assign out_ch.charge_known   = out_r.charge_known;
  assign out_ch.charge_level   = out_r.charge_level;
  assign out_ch.low_state      = out_r.low_state;
  assign out_ch.charging_known = out_r.charging_known;
  assign out_ch.is_charging    = out_r.is_charging;
  assign out_ch.time_known     = out_r.time_known;
  assign out_ch.time_minutes   = out_r.time_minutes;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry without output entry");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ch.ready |=> skid_valid_r && $stable(skid_r))
    else $error("skid entry lost while output stalled");

  a_disabled_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !cfg_r.enable |-> res.action == bpsh_pkg::ACT_NONE && !res.warning)
    else $error("activity while disabled");

  a_alarm_action: assert property (@(posedge clk) disable iff (!rst_n)
    acc && cfg_r.enable && cfg_r.use_alarm |->
      res.action == bpsh_pkg::ACT_NONE || res.action == bpsh_pkg::ACT_PIN)
    else $error("gauge scan in alarm mode");
`endif

endmodule
